/* rtl/lsqe_pkg.sv */
// ----------------------------------------------------------------------------
// lsqe_pkg
// Shared types and constants of the line strip quad expander.
// ----------------------------------------------------------------------------
`default_nettype none
package lsqe_pkg;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned HalfWidth  = 31;
   localparam int unsigned NumRegs    = 4;
   localparam int unsigned RegIdxWidth = 2;

   localparam logic [RegIdxWidth-1:0] REG_CAMERA_X   = 2'd0;
   localparam logic [RegIdxWidth-1:0] REG_CAMERA_Y   = 2'd1;
   localparam logic [RegIdxWidth-1:0] REG_CAMERA_Z   = 2'd2;
   localparam logic [RegIdxWidth-1:0] REG_HALF_WIDTH = 2'd3;

   localparam logic [HalfWidth-1:0] HALF_WIDTH_RESET = 31'd65536;

   typedef struct packed {
      logic                         first_point;
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic signed [CoordWidth-1:0] point_z;
      logic [CoordWidth-1:0]        point_color;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] vertex_x;
      logic signed [CoordWidth-1:0] vertex_y;
      logic signed [CoordWidth-1:0] vertex_z;
      logic [CoordWidth-1:0]        vertex_color;
      logic                         tex_u;
      logic                         tex_v;
      logic                         last_vertex;
   } rsp_type;

   typedef struct packed {
      logic [RegIdxWidth-1:0] index;
      logic [CoordWidth-1:0]  data;
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHRINK,
      ST_CROSS,
      ST_NORM,
      ST_SQ,
      ST_SQRT,
      ST_DIV,
      ST_EMIT
   } state_type;
endpackage
`default_nettype wire

/* rtl/lsqe_if.sv */
// ----------------------------------------------------------------------------
// lsqe_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface lsqe_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/lsqe_div.sv */
// ----------------------------------------------------------------------------
// lsqe_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lsqe_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   import lsqe_pkg::*;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit and try a subtract
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = busy_ff && (cnt_ff == 7'd1);
   assign quotient = {quo_ff[62:0], (trial >= {1'b0, dsr_ff})};
endmodule
`default_nettype wire

/* rtl/line_strip_quad_expander.sv */
// ----------------------------------------------------------------------------
// line_strip_quad_expander
// Expands line strip points into camera-facing quad vertices.
// ----------------------------------------------------------------------------
// channel | dir | payload                                   | accepted when
// req     | in  | first_point, point_x/y/z, point_color     | valid && ready
// rsp     | out | vertex_x/y/z, vertex_color, tex_u/v, last | valid && ready
// csr     | in  | index, data (camera_x/y/z, half_width)    | valid && ready
//
// A strip start only records its point and emits no vertex. A continuing point
// runs accept, shrink, cross, normalize, squares, square root and three serial
// divides, then emits its two or four vertices. A zero-length side skips the
// squares, root and divides. Reset clears control state and the registers to
// their reset values. A stalled rsp holds the vertex on offer.
// ----------------------------------------------------------------------------
`default_nettype none
module line_strip_quad_expander (
   input  wire logic clock,
   input  wire logic reset,
   lsqe_if.sink      req,
   lsqe_if.source    rsp,
   lsqe_if.sink      csr
);
   import lsqe_pkg::*;

   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [30:0]        hw_ff;
   logic signed [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [31:0]        prev_c_ff;
   logic [1:0]         seen_ff;
   logic signed [31:0] bx_ff, by_ff, bz_ff;
   logic [31:0]        bc_ff;

   state_type          state_ff, state_in;
   logic signed [33:0] d_ff [3];
   logic signed [33:0] w_ff [3];
   logic signed [63:0] c_ff [3];
   logic [63:0]        m_ff [3];
   logic [1:0]         neg_dummy;
   logic [2:0]         neg_ff;
   logic [2:0]         step_ff;
   logic [63:0]        acc_ff;
   logic [63:0]        sqx_ff, sqr_ff, sqb_ff;
   logic [31:0]        len_ff;
   logic [1:0]         di_ff;
   logic signed [32:0] side_ff [3];
   logic [1:0]         vi_ff, vlast_ff;

   // csr writes are taken at any time
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0; cam_y_ff <= '0; cam_z_ff <= '0;
         hw_ff <= HALF_WIDTH_RESET;
      end else if (csr.valid) begin
         unique case (csr.payload.index)
            REG_CAMERA_X:   cam_x_ff <= csr.payload.data;
            REG_CAMERA_Y:   cam_y_ff <= csr.payload.data;
            REG_CAMERA_Z:   cam_z_ff <= csr.payload.data;
            REG_HALF_WIDTH: hw_ff    <= csr.payload.data[30:0];
            default: ;
         endcase
      end
   end

   // one shared multiplier, selected by state and step
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;

   // divider, started by a registered go in the cycle its operands are in place
   logic        div_start, div_done;
   logic        div_go_ff, div_go_in;
   logic [63:0] div_quo;
   logic [63:0] div_num;
   assign div_num = $unsigned(mul_p) + {33'd0, len_ff[31:1]};
   lsqe_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_num), .divisor(len_ff),
      .done(div_done), .quotient(div_quo)
   );

   logic req_fire, rsp_fire;
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign neg_dummy = '0;

   // helpers
   function automatic logic [33:0] mag34(logic signed [33:0] v);
      return v[33] ? 34'(-v) : 34'(v);
   endfunction
   function automatic logic [63:0] mag64(logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction
   function automatic logic signed [33:0] shr1(logic signed [33:0] v);
      logic [33:0] m;
      m = mag34(v) >> 1;
      return v[33] ? -$signed(m) : $signed(m);
   endfunction

   logic any_d_big, any_w_big, big_c, small_c, zero_c;
   always_comb begin
      any_d_big = (mag34(d_ff[0]) >= 34'h40000000) || (mag34(d_ff[1]) >= 34'h40000000)
               || (mag34(d_ff[2]) >= 34'h40000000);
      any_w_big = (mag34(w_ff[0]) >= 34'h40000000) || (mag34(w_ff[1]) >= 34'h40000000)
               || (mag34(w_ff[2]) >= 34'h40000000);
      big_c  = (m_ff[0] >= 64'h40000000) || (m_ff[1] >= 64'h40000000)
            || (m_ff[2] >= 64'h40000000);
      small_c = (m_ff[0] < 64'h20000000) && (m_ff[1] < 64'h20000000)
             && (m_ff[2] < 64'h20000000);
      zero_c = (m_ff[0] == 0) && (m_ff[1] == 0) && (m_ff[2] == 0);
   end

   always_comb begin
      mul_a = '0; mul_b = '0;
      if (state_ff == ST_CROSS) begin
         unique case (step_ff)
            3'd0: begin mul_a = 32'(d_ff[1]); mul_b = 32'(w_ff[2]); end
            3'd1: begin mul_a = 32'(d_ff[2]); mul_b = 32'(w_ff[1]); end
            3'd2: begin mul_a = 32'(d_ff[2]); mul_b = 32'(w_ff[0]); end
            3'd3: begin mul_a = 32'(d_ff[0]); mul_b = 32'(w_ff[2]); end
            3'd4: begin mul_a = 32'(d_ff[0]); mul_b = 32'(w_ff[1]); end
            3'd5: begin mul_a = 32'(d_ff[1]); mul_b = 32'(w_ff[0]); end
            default: ;
         endcase
      end else if (state_ff == ST_DIV) begin
         // magnitude times half width for the divider
         mul_a = $signed({1'b0, m_ff[di_ff][30:0]});
         mul_b = $signed({1'b0, hw_ff});
      end else if (state_ff == ST_SQ && step_ff < 3'd3) begin
         mul_a = $signed(m_ff[step_ff[1:0]][31:0]);
         mul_b = $signed(m_ff[step_ff[1:0]][31:0]);
      end
      mul_p = mul_a * mul_b;
   end

   // square root step
   logic [63:0] sq_trial;
   assign sq_trial = sqr_ff + sqb_ff;

   always_comb begin
      state_in  = state_ff;
      div_go_in = 1'b0;
      unique case (state_ff)
         ST_IDLE:  if (req_fire && !(req.payload.first_point || seen_ff == 2'd0))
                      state_in = ST_SHRINK;
         ST_SHRINK: if (!any_d_big && !any_w_big) state_in = ST_CROSS;
         ST_CROSS: if (step_ff == 3'd5) state_in = ST_NORM;
         ST_NORM:  if (zero_c) state_in = ST_EMIT;
                   else if (!big_c && !small_c) state_in = ST_SQ;
         ST_SQ:    if (step_ff == 3'd3) state_in = ST_SQRT;
         ST_SQRT:  if (sqb_ff == 64'd0) begin
                      if (sqr_ff == 64'd0) state_in = ST_EMIT;
                      else begin
                         state_in = ST_DIV;
                         div_go_in = 1'b1;
                      end
                   end
         ST_DIV:   if (div_done) begin
                      if (di_ff == 2'd2) state_in = ST_EMIT;
                      else div_go_in = 1'b1;
                   end
         ST_EMIT:  if (rsp_fire && vi_ff == vlast_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         div_go_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= div_go_in;
      end
   end
   assign div_start = div_go_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         prev_x_ff <= '0; prev_y_ff <= '0; prev_z_ff <= '0; prev_c_ff <= '0;
         step_ff <= '0;
         di_ff <= '0;
         vi_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_fire) begin
               bx_ff <= req.payload.point_x; by_ff <= req.payload.point_y;
               bz_ff <= req.payload.point_z; bc_ff <= req.payload.point_color;
               d_ff[0] <= 34'(req.payload.point_x) - 34'(prev_x_ff);
               d_ff[1] <= 34'(req.payload.point_y) - 34'(prev_y_ff);
               d_ff[2] <= 34'(req.payload.point_z) - 34'(prev_z_ff);
               w_ff[0] <= 34'(req.payload.point_x) - 34'(cam_x_ff);
               w_ff[1] <= 34'(req.payload.point_y) - 34'(cam_y_ff);
               w_ff[2] <= 34'(req.payload.point_z) - 34'(cam_z_ff);
               step_ff <= '0;
               for (int i = 0; i < 3; i++) side_ff[i] <= '0;
               if (req.payload.first_point || seen_ff == 2'd0) begin
                  seen_ff <= 2'd1;
                  prev_x_ff <= req.payload.point_x; prev_y_ff <= req.payload.point_y;
                  prev_z_ff <= req.payload.point_z; prev_c_ff <= req.payload.point_color;
               end else begin
                  vi_ff <= (seen_ff == 2'd1) ? 2'd0 : 2'd2;
               end
            end
            ST_SHRINK: begin
               if (any_d_big) for (int i = 0; i < 3; i++) d_ff[i] <= shr1(d_ff[i]);
               if (any_w_big) for (int i = 0; i < 3; i++) w_ff[i] <= shr1(w_ff[i]);
            end
            ST_CROSS: begin
               unique case (step_ff)
                  3'd0: c_ff[0] <= mul_p;
                  3'd1: c_ff[0] <= c_ff[0] - mul_p;
                  3'd2: c_ff[1] <= mul_p;
                  3'd3: c_ff[1] <= c_ff[1] - mul_p;
                  3'd4: c_ff[2] <= mul_p;
                  3'd5: c_ff[2] <= c_ff[2] - mul_p;
                  default: ;
               endcase
               step_ff <= (step_ff == 3'd5) ? 3'd0 : step_ff + 3'd1;
               if (step_ff == 3'd5) begin
                  for (int i = 0; i < 3; i++) begin
                     m_ff[i]  <= (i == 0) ? mag64(c_ff[0]) : (i == 1) ? mag64(c_ff[1])
                                 : mag64(c_ff[2] - mul_p);
                     neg_ff[i] <= (i == 2) ? (c_ff[2] - mul_p) < 0 : c_ff[i] < 0;
                  end
               end
            end
            ST_NORM: begin
               if (big_c)        for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
               else if (small_c) for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
               acc_ff <= '0;
               step_ff <= '0;
            end
            ST_SQ: begin
               if (step_ff != 3'd3) acc_ff <= acc_ff + 64'(mul_p);
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd3) begin
                  sqx_ff <= acc_ff;
                  sqr_ff <= '0;
                  sqb_ff <= 64'h4000000000000000;
               end
            end
            ST_SQRT: begin
               if (sqb_ff > sqx_ff && sqr_ff == 64'd0) begin
                  sqb_ff <= sqb_ff >> 2;
               end else if (sqb_ff != 64'd0) begin
                  if (sqx_ff >= sq_trial) begin
                     sqx_ff <= sqx_ff - sq_trial;
                     sqr_ff <= (sqr_ff >> 1) + sqb_ff;
                  end else begin
                     sqr_ff <= sqr_ff >> 1;
                  end
                  sqb_ff <= sqb_ff >> 2;
               end else begin
                  len_ff <= sqr_ff[31:0];
                  di_ff <= '0;
               end
            end
            ST_DIV: if (div_done) begin
               side_ff[di_ff] <= neg_ff[di_ff] ? -$signed({1'b0, div_quo[31:0]})
                                               : $signed({1'b0, div_quo[31:0]});
               di_ff <= di_ff + 2'd1;
            end
            ST_EMIT: if (rsp_fire) begin
               vi_ff <= vi_ff + 2'd1;
               if (vi_ff == vlast_ff) begin
                  seen_ff <= 2'd2;
                  prev_x_ff <= bx_ff; prev_y_ff <= by_ff;
                  prev_z_ff <= bz_ff; prev_c_ff <= bc_ff;
               end
            end
            default: ;
         endcase
      end
   end
   assign vlast_ff = 2'd3;

   // vertex assembly
   function automatic logic signed [31:0] sat(logic signed [33:0] v);
      if (v > 34'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (v < -34'sh80000000) return 32'h80000000;
      return v[31:0];
   endfunction
   logic               at_prev, minus;
   logic signed [31:0] px, py, pz;
   always_comb begin
      at_prev = !vi_ff[1];
      minus   = vi_ff[0];
      px = at_prev ? prev_x_ff : bx_ff;
      py = at_prev ? prev_y_ff : by_ff;
      pz = at_prev ? prev_z_ff : bz_ff;
      rsp.payload.vertex_x = sat(minus ? 34'(px) - 34'(side_ff[0]) : 34'(px) + 34'(side_ff[0]));
      rsp.payload.vertex_y = sat(minus ? 34'(py) - 34'(side_ff[1]) : 34'(py) + 34'(side_ff[1]));
      rsp.payload.vertex_z = sat(minus ? 34'(pz) - 34'(side_ff[2]) : 34'(pz) + 34'(side_ff[2]));
      rsp.payload.vertex_color = at_prev ? prev_c_ff : bc_ff;
      rsp.payload.tex_u = !at_prev;
      rsp.payload.tex_v = minus;
      rsp.payload.last_vertex = (vi_ff == vlast_ff) && (neg_dummy == 2'd0);
   end
   assign rsp.valid = (state_ff == ST_EMIT);

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("item taken while busy");
   a_last_leaves: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp.payload.last_vertex) |=> (state_ff == ST_IDLE))
      else $error("last vertex did not end item");
   a_rsp_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (seen_ff != 2'd0)) else $error("vertex without strip");
endmodule
`default_nettype wire
